/* design/gscb_pkg.sv */
package gscb_pkg;

	// Field widths of the channels
	localparam int KEY_W = 64;
	localparam int POS_W = 31;
	localparam int ERR_BITS = 16;

	// Bits of key and position that take part in the arithmetic
	localparam int KEY_BITS = 64;
	localparam int POS_BITS = 31;

	// Slope numerator: position difference +- max_error, signed
	localparam int NUM_BITS = ((POS_BITS > ERR_BITS) ? POS_BITS : ERR_BITS) + 2;
	// |numerator| always stays below 2^32
	localparam int MAG_BITS = 32;
	// Denominators are split into two halves for the 32x32 multiplier
	localparam int HALF_BITS = 32;
	localparam int DEN_BITS = 2 * HALF_BITS;
	// n1*d2 - n2*d1, signed
	localparam int ACC_BITS = MAG_BITS + DEN_BITS + 2;

	// APB
	localparam int PADDR_BITS = 3;
	localparam int APB_DATA = 32;
	localparam logic [ERR_BITS-1:0] MAX_ERROR_RESET = 16'd32;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic signed [NUM_BITS-1:0] num_t;

	typedef struct packed {
		logic [KEY_W-1:0] point_key;
		logic [POS_W-1:0] point_position;
		logic             stream_end;
	} point_t;

	typedef struct packed {
		logic [KEY_W-1:0] knot_key;
		logic [POS_W-1:0] knot_position;
		logic             run_last;
	} knot_t;

	// Slope compare request: sign of n1/d1 - n2/d2, dens positive
	typedef struct packed {
		logic start;
		num_t n1;
		key_t d1;
		num_t n2;
		key_t d2;
	} cmp_req_t;

	typedef struct packed {
		logic done;
		logic lt;
		logic gt;
	} cmp_rsp_t;

endpackage

/* design/gscb_cmp_unit.sv */
module gscb_cmp_unit import gscb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cmp_req_t req,
	output cmp_rsp_t rsp
);

	// steps 0..3 issue partial products, step 5 presents the result
	localparam logic [2:0] STEP_LAST_MUL = 3'd3;
	localparam logic [2:0] STEP_DONE = 3'd5;

	logic                    busy_q;
	logic [2:0]              step_q;
	logic [MAG_BITS-1:0]     m1_q, m2_q;
	logic                    neg1_q, neg2_q;
	logic [DEN_BITS-1:0]     d1_q, d2_q;
	logic [2*HALF_BITS-1:0]  prod_s1;
	logic                    neg_s1, hi_s1, vld_s1;
	logic [ACC_BITS-1:0]     acc_q;

	logic [MAG_BITS-1:0]     mul_a;
	logic [DEN_BITS-1:0]     den_sel;
	logic [HALF_BITS-1:0]    mul_b;
	logic [ACC_BITS-1:0]     term;
	logic [ACC_BITS-1:0]     acc_next;
	logic                    issue;

	function automatic logic [MAG_BITS-1:0] mag(input num_t n);
		num_t m;
		m = n[NUM_BITS-1] ? -n : n;
		return MAG_BITS'(unsigned'(m));
	endfunction

	// step bit 1 picks the product (n1*d2 or n2*d1), bit 0 the den half
	assign issue = busy_q && (step_q <= STEP_LAST_MUL);
	assign mul_a = step_q[1] ? m2_q : m1_q;
	assign den_sel = step_q[1] ? d1_q : d2_q;
	assign mul_b = step_q[0] ? den_sel[DEN_BITS-1:HALF_BITS] : den_sel[HALF_BITS-1:0];

	assign term = hi_s1 ? (ACC_BITS'(prod_s1) << HALF_BITS) : ACC_BITS'(prod_s1);
	assign acc_next = neg_s1 ? (acc_q - term) : (acc_q + term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_DONE) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= (2*HALF_BITS)'(mul_a) * (2*HALF_BITS)'(mul_b);
			neg_s1 <= step_q[1] ? ~neg2_q : neg1_q;
			hi_s1 <= step_q[0];
		end
		if (req.start) begin
			m1_q <= mag(req.n1);
			neg1_q <= req.n1[NUM_BITS-1];
			m2_q <= mag(req.n2);
			neg2_q <= req.n2[NUM_BITS-1];
			d1_q <= DEN_BITS'(req.d1);
			d2_q <= DEN_BITS'(req.d2);
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_next;
		end
	end

	assign rsp.done = busy_q && (step_q == STEP_DONE);
	assign rsp.lt = acc_q[ACC_BITS-1];
	assign rsp.gt = !acc_q[ACC_BITS-1] && (|acc_q);

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("compare started while busy");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> ##6 rsp.done)
		else $error("compare result not on time");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= STEP_DONE))
		else $error("compare step out of range");
`endif

endmodule

/* design/greedy_spline_corridor_builder.sv */
// Channel   Dir  Payload   Handshake                    Transaction when
// point     in   point_t   point_valid / point_stall    valid && !stall
// knot      out  knot_t    knot_valid / knot_stall      valid && !stall
// apb       in   max_error psel penable pwrite pready   write: psel&penable&pwrite
//
// Per point: a first point goes to S_OUT for its knot; a dropped key returns to
// S_IDLE, or goes to S_OUT for a stream-end knot; otherwise, for each compare, S_GO
// skips an open bound or launches the slope compare and waits in S_WAIT, then S_MISS
// on a miss, S_FIN, and S_OUT once per knot handed out. Inside a closed corridor:
// four compares; a miss ends after the first or second compare. Each compare is
// four 32x32 partial products through the one shared multiplier.
// point_stall is high from acceptance until the point's knots are handed to
// the output register; a knot waiting under knot_stall does not block the next
// point, only the emission of that point's own knots.
// Reset clears the corridor state and sets max_error to 32; no clearing pass.
module greedy_spline_corridor_builder import gscb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// point channel
	input  logic                  point_valid,
	output logic                  point_stall,
	input  point_t                point_data,
	// knot channel
	output logic                  knot_valid,
	input  logic                  knot_stall,
	output knot_t                 knot_data,
	// APB
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [APB_DATA-1:0]   pwdata,
	output logic [APB_DATA-1:0]   prdata,
	output logic                  pready
);

	localparam logic REG_MAX_ERROR = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,  // ready for a point
		S_PROC,  // classify the point, set up slope terms
		S_GO,    // launch next compare or skip an open bound
		S_WAIT,  // compare in flight
		S_MISS,  // close the end as a knot, reopen corridor from it
		S_FIN,   // point becomes the end, stream-end handling
		S_OUT    // hand pending knots to the output register
	} state_t;

	// compare being run: slope vs upper/lower, then narrowed bound vs old bound
	typedef enum logic [1:0] {
		OP_DU,
		OP_DL,
		OP_NU,
		OP_NL
	} op_t;

	state_t              state_q;
	op_t                 op_q;

	logic [ERR_BITS-1:0] max_error_q;

	key_t                key_q;
	pos_t                pos_q;
	logic                fin_q;

	logic                have_base_q, have_end_q;
	key_t                base_key_q, end_key_q;
	pos_t                base_pos_q, end_pos_q;
	num_t                upper_num_q, lower_num_q;
	key_t                upper_den_q, lower_den_q;
	logic                upper_open_q, lower_open_q;

	key_t                dk_q;
	num_t                ds_q, up_q, lo_q;

	logic                pend_a_q, pend_b_q;
	key_t                a_key_q;
	pos_t                a_pos_q;

	logic                out_valid_q;
	knot_t               out_q;

	cmp_req_t            cmp_req;
	cmp_rsp_t            cmp_rsp;

	logic                cfg_wr;
	logic                accept;
	logic                slot_free;
	logic                clr;
	logic                sel_upper;
	logic                sel_open;
	num_t                err_n;
	key_t                dk_base, dk_end;
	num_t                ds_base, ds_end;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_BITS-1:2] == REG_MAX_ERROR);
	assign prdata = (paddr[PADDR_BITS-1:2] == REG_MAX_ERROR) ?
		APB_DATA'(max_error_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_error_q <= MAX_ERROR_RESET;
		end else if (cfg_wr) begin
			max_error_q <= pwdata[ERR_BITS-1:0];
		end
	end

	// ---------------------------------------------------------- handshakes
	assign point_stall = (state_q != S_IDLE);
	assign accept = point_valid && !point_stall;
	assign knot_valid = out_valid_q;
	assign knot_data = out_q;
	assign slot_free = !out_valid_q || !knot_stall;

	// ------------------------------------------------------ slope terms
	assign err_n = $signed(NUM_BITS'(max_error_q));
	assign dk_base = key_q - base_key_q;
	assign ds_base = $signed(NUM_BITS'(pos_q)) - $signed(NUM_BITS'(base_pos_q));
	assign dk_end = key_q - end_key_q;
	assign ds_end = $signed(NUM_BITS'(pos_q)) - $signed(NUM_BITS'(end_pos_q));

	// shared compare unit operands
	assign sel_upper = (op_q == OP_DU) || (op_q == OP_NU);
	assign sel_open = sel_upper ? upper_open_q : lower_open_q;

	always_comb begin
		cmp_req.start = (state_q == S_GO) && !sel_open;
		cmp_req.d1 = dk_q;
		cmp_req.n2 = sel_upper ? upper_num_q : lower_num_q;
		cmp_req.d2 = sel_upper ? upper_den_q : lower_den_q;
		case (op_q)
			OP_DU, OP_DL: cmp_req.n1 = ds_q;
			OP_NU:        cmp_req.n1 = up_q;
			OP_NL:        cmp_req.n1 = lo_q;
			default:      cmp_req.n1 = ds_q;
		endcase
	end

	gscb_cmp_unit u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmp_req),
		.rsp    (cmp_rsp)
	);

	// stream end wipes the corridor once the point is handled
	assign clr = fin_q && ((state_q == S_FIN)
		|| ((state_q == S_PROC) && !(have_base_q && (key_q > end_key_q))));

	// ------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_DU;
			key_q <= '0;
			pos_q <= '0;
			fin_q <= 1'b0;
			have_base_q <= 1'b0;
			have_end_q <= 1'b0;
			base_key_q <= '0;
			base_pos_q <= '0;
			end_key_q <= '0;
			end_pos_q <= '0;
			upper_num_q <= '0;
			upper_den_q <= '0;
			upper_open_q <= 1'b1;
			lower_num_q <= '0;
			lower_den_q <= '0;
			lower_open_q <= 1'b1;
			dk_q <= '0;
			ds_q <= '0;
			up_q <= '0;
			lo_q <= '0;
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
			a_key_q <= '0;
			a_pos_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && !knot_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= point_data.point_key[KEY_BITS-1:0];
						pos_q <= point_data.point_position[POS_BITS-1:0];
						fin_q <= point_data.stream_end;
						state_q <= S_PROC;
					end
				end

				S_PROC: begin
					pend_b_q <= 1'b0;
					if (!have_base_q) begin
						// first point: base, end and a knot
						have_base_q <= 1'b1;
						have_end_q <= 1'b0;
						base_key_q <= key_q;
						base_pos_q <= pos_q;
						end_key_q <= key_q;
						end_pos_q <= pos_q;
						upper_open_q <= 1'b1;
						lower_open_q <= 1'b1;
						pend_a_q <= 1'b1;
						a_key_q <= key_q;
						a_pos_q <= pos_q;
						state_q <= S_OUT;
					end else if (key_q > end_key_q) begin
						dk_q <= dk_base;
						ds_q <= ds_base;
						up_q <= ds_base + err_n;
						lo_q <= ds_base - err_n;
						op_q <= OP_DU;
						pend_a_q <= 1'b0;
						state_q <= S_GO;
					end else begin
						// key not past the end: dropped, stream end still counts
						pend_a_q <= fin_q && have_end_q;
						a_key_q <= end_key_q;
						a_pos_q <= end_pos_q;
						state_q <= (fin_q && have_end_q) ? S_OUT : S_IDLE;
					end
				end

				S_GO: begin
					case (op_q)
						OP_DU: begin
							if (upper_open_q) begin
								op_q <= OP_DL;
							end else begin
								state_q <= S_WAIT;
							end
						end
						OP_DL: begin
							if (lower_open_q) begin
								op_q <= OP_NU;
							end else begin
								state_q <= S_WAIT;
							end
						end
						OP_NU: begin
							if (upper_open_q) begin
								upper_num_q <= up_q;
								upper_den_q <= dk_q;
								upper_open_q <= 1'b0;
								op_q <= OP_NL;
							end else begin
								state_q <= S_WAIT;
							end
						end
						OP_NL: begin
							if (lower_open_q) begin
								lower_num_q <= lo_q;
								lower_den_q <= dk_q;
								lower_open_q <= 1'b0;
								state_q <= S_FIN;
							end else begin
								state_q <= S_WAIT;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end

				S_WAIT: begin
					if (cmp_rsp.done) begin
						case (op_q)
							OP_DU: begin
								if (cmp_rsp.lt) begin
									op_q <= OP_DL;
									state_q <= S_GO;
								end else begin
									state_q <= S_MISS;
								end
							end
							OP_DL: begin
								if (cmp_rsp.gt) begin
									op_q <= OP_NU;
									state_q <= S_GO;
								end else begin
									state_q <= S_MISS;
								end
							end
							OP_NU: begin
								if (cmp_rsp.lt) begin
									upper_num_q <= up_q;
									upper_den_q <= dk_q;
									upper_open_q <= 1'b0;
								end
								op_q <= OP_NL;
								state_q <= S_GO;
							end
							OP_NL: begin
								if (cmp_rsp.gt) begin
									lower_num_q <= lo_q;
									lower_den_q <= dk_q;
									lower_open_q <= 1'b0;
								end
								state_q <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end

				S_MISS: begin
					// end becomes a knot and the new base
					pend_a_q <= 1'b1;
					a_key_q <= end_key_q;
					a_pos_q <= end_pos_q;
					base_key_q <= end_key_q;
					base_pos_q <= end_pos_q;
					upper_num_q <= ds_end + err_n;
					upper_den_q <= dk_end;
					upper_open_q <= 1'b0;
					lower_num_q <= ds_end - err_n;
					lower_den_q <= dk_end;
					lower_open_q <= 1'b0;
					state_q <= S_FIN;
				end

				S_FIN: begin
					end_key_q <= key_q;
					end_pos_q <= pos_q;
					have_end_q <= 1'b1;
					pend_b_q <= fin_q;
					state_q <= (pend_a_q || fin_q) ? S_OUT : S_IDLE;
				end

				S_OUT: begin
					if (slot_free) begin
						if (pend_a_q) begin
							out_q.knot_key <= KEY_W'(a_key_q);
							out_q.knot_position <= POS_W'(a_pos_q);
							out_q.run_last <= !pend_b_q;
							out_valid_q <= 1'b1;
							pend_a_q <= 1'b0;
							if (!pend_b_q) begin
								state_q <= S_IDLE;
							end
						end else if (pend_b_q) begin
							// trailing end knot on stream end is the point itself
							out_q.knot_key <= KEY_W'(key_q);
							out_q.knot_position <= POS_W'(pos_q);
							out_q.run_last <= 1'b1;
							out_valid_q <= 1'b1;
							pend_b_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase

			if (clr) begin
				have_base_q <= 1'b0;
				have_end_q <= 1'b0;
				base_key_q <= '0;
				base_pos_q <= '0;
				end_key_q <= '0;
				end_pos_q <= '0;
				upper_num_q <= '0;
				upper_den_q <= '0;
				upper_open_q <= 1'b1;
				lower_num_q <= '0;
				lower_den_q <= '0;
				lower_open_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> point_stall)
		else $error("point accepted but block not busy");

	a_end_needs_base: assert property (@(posedge clk) disable iff (!arst_n)
		have_end_q |-> have_base_q)
		else $error("end point without base");

	a_knot_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(knot_valid) |-> $past(state_q == S_OUT))
		else $error("knot issued outside output state");

	a_wait_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) && cmp_rsp.done |=> (state_q != S_WAIT))
		else $error("compare done but sequencer still waiting");
`endif

endmodule

/* test/greedy_spline_corridor_builder_tb.sv */
`timescale 1ns / 1ps

// Corridor spline builder bench: a directed table, then random sorted streams
// checked knot by knot against a local model of the slope corridor.
module greedy_spline_corridor_builder_tb;
	import gscb_pkg::*;

	localparam logic [PADDR_BITS-1:0] ADDR_MAX_ERROR = '0;
	// idle cycles after the last knot; a corridor point can still be running
	localparam int SETTLE_CYCLES = 60;
	// long receiver hold-off, enough to back the block up into point_stall
	localparam int HOLD_CYCLES = 300;
	localparam int SEGMENT_POINTS = 217;
	localparam longint POS_TOP = 64'sd2147483647;
	localparam logic [63:0] KEY_TOP = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

	// One row of the directed table. tn < 0: knots come from the model,
	// else tn knots are typed in (at most one, always the last of its step).
	typedef struct packed {
		logic signed [31:0] err;
		point_t             pt;
		logic signed [31:0] tn;
		knot_t              tk;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  point_valid = 1'b0;
	logic                  point_stall;
	point_t                point_data = '0;
	logic                  knot_valid;
	logic                  knot_stall = 1'b0;
	knot_t                 knot_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA-1:0]   pwdata = '0;
	logic [APB_DATA-1:0]   prdata;
	logic                  pready;

	greedy_spline_corridor_builder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_data  (point_data),
		.knot_valid  (knot_valid),
		.knot_stall  (knot_stall),
		.knot_data   (knot_data),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Local corridor model: base knot, tentative end, two slope bounds kept
	// as exact fractions num/den (den = key distance, always >= 1).
	// ---------------------------------------------------------------------
	logic [15:0] cor_max_error;
	bit          cor_have_base, cor_have_end;
	logic [63:0] cor_base_key, cor_end_key, cor_up_den, cor_lo_den;
	longint      cor_base_pos, cor_end_pos, cor_up_num, cor_lo_num;
	bit          cor_up_open, cor_lo_open;

	knot_t       pending_knots[$];
	stim_row_t   stim_rows[$];
	int          mismatches = 0;
	int          knots_seen = 0;
	int          points_sent = 0;
	int          cfg_writes = 0;
	int          tx_idle_pct = 13;
	int          rx_idle_pct = 50;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	function automatic void corridor_clear();
		cor_have_base = 1'b0;
		cor_have_end = 1'b0;
		cor_base_key = '0;
		cor_base_pos = 0;
		cor_end_key = '0;
		cor_end_pos = 0;
		cor_up_num = 0;
		cor_up_den = '0;
		cor_up_open = 1'b1;
		cor_lo_num = 0;
		cor_lo_den = '0;
		cor_lo_open = 1'b1;
	endfunction

	// sign of n1/d1 - n2/d2 by cross-multiplication, exact at 130 bits
	function automatic int slope_cmp(input longint n1, input logic [63:0] d1,
			input longint n2, input logic [63:0] d2);
		logic signed [129:0] lhs, rhs;
		lhs = 130'(n1) * $signed({66'd0, d2});
		rhs = 130'(n2) * $signed({66'd0, d1});
		if (lhs < rhs)
			return -1;
		if (lhs > rhs)
			return 1;
		return 0;
	endfunction

	// One point through the corridor; returns the number of knots it emits.
	function automatic int corridor_step(input point_t pt, output knot_t k0,
			output knot_t k1);
		logic [63:0] key, dk;
		longint      pos, ds, up, lo, err;
		bit          in_band;
		int          n;
		knot_t       r[2];
		key = pt.point_key;
		pos = longint'(pt.point_position);
		err = longint'(cor_max_error);
		n = 0;
		r[0] = '0;
		r[1] = '0;
		if (!cor_have_base) begin
			// first point of a stream: base, end and a knot at once
			cor_have_base = 1'b1;
			cor_have_end = 1'b0;
			cor_base_key = key;
			cor_base_pos = pos;
			cor_end_key = key;
			cor_end_pos = pos;
			cor_up_open = 1'b1;
			cor_lo_open = 1'b1;
			r[n].knot_key = key;
			r[n].knot_position = pos[30:0];
			n++;
		end else if (key > cor_end_key) begin
			dk = key - cor_base_key;
			ds = pos - cor_base_pos;
			in_band = (cor_up_open || slope_cmp(ds, dk, cor_up_num, cor_up_den) < 0) &&
				(cor_lo_open || slope_cmp(ds, dk, cor_lo_num, cor_lo_den) > 0);
			if (in_band) begin
				// narrow each bound only where the new one is tighter
				up = ds + err;
				lo = ds - err;
				if (cor_up_open || slope_cmp(up, dk, cor_up_num, cor_up_den) < 0) begin
					cor_up_num = up;
					cor_up_den = dk;
					cor_up_open = 1'b0;
				end
				if (cor_lo_open || slope_cmp(lo, dk, cor_lo_num, cor_lo_den) > 0) begin
					cor_lo_num = lo;
					cor_lo_den = dk;
					cor_lo_open = 1'b0;
				end
			end else begin
				// miss: the end becomes a knot and a new corridor opens from it
				r[n].knot_key = cor_end_key;
				r[n].knot_position = cor_end_pos[30:0];
				n++;
				cor_base_key = cor_end_key;
				cor_base_pos = cor_end_pos;
				dk = key - cor_base_key;
				ds = pos - cor_base_pos;
				cor_up_num = ds + err;
				cor_up_den = dk;
				cor_up_open = 1'b0;
				cor_lo_num = ds - err;
				cor_lo_den = dk;
				cor_lo_open = 1'b0;
			end
			cor_end_key = key;
			cor_end_pos = pos;
			cor_have_end = 1'b1;
		end
		if (pt.stream_end) begin
			if (cor_have_end) begin
				r[n].knot_key = cor_end_key;
				r[n].knot_position = cor_end_pos[30:0];
				n++;
			end
			corridor_clear();
		end
		if (n > 0)
			r[n-1].run_last = 1'b1;
		k0 = r[0];
		k1 = r[1];
		return n;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH knot %0d %s: got %h want %h", knots_seen, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------------
	// Knot side: check each knot transaction against the oldest pending
	// knot, then pick next cycle's stall (random, or a long hold-off).
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : knot_monitor
		knot_t want;
		if (arst_n && knot_valid && !knot_stall) begin
			knots_seen++;
			if (pending_knots.size() == 0) begin
				report_mismatch("arrived with none pending", knot_data.knot_key, '0);
			end else begin
				want = pending_knots.pop_front();
				if (knot_data.knot_key !== want.knot_key)
					report_mismatch("knot_key", knot_data.knot_key, want.knot_key);
				if (knot_data.knot_position !== want.knot_position)
					report_mismatch("knot_position", 64'(knot_data.knot_position),
						64'(want.knot_position));
				if (knot_data.run_last !== want.run_last)
					report_mismatch("run_last", 64'(knot_data.run_last), 64'(want.run_last));
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			knot_stall <= 1'b1;
			hold_left--;
		end else begin
			knot_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Point side
	// ---------------------------------------------------------------------

	// Offer one point, hold it until the transaction, then predict its knots.
	task automatic feed_point(input point_t pt, input bit typed, input int tn,
			input knot_t tk);
		knot_t r0, r1;
		int    n;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point_data <= pt;
		point_valid <= 1'b1;
		@(posedge clk);
		while (point_stall)
			@(posedge clk);
		points_sent++;
		n = corridor_step(pt, r0, r1);
		if (typed) begin
			if (tn > 0)
				pending_knots = {pending_knots, tk};
		end else begin
			if (n > 0)
				pending_knots = {pending_knots, r0};
			if (n > 1)
				pending_knots = {pending_knots, r1};
		end
	endtask

	// Sender pauses until every knot is out, then lets a busy point finish
	// (a point inside the corridor leaves nothing pending while it runs).
	task automatic drain_knots();
		point_valid <= 1'b0;
		while (pending_knots.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [15:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_MAX_ERROR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// access phase ends here; prdata is sampled before the edge updates
		if (prdata !== {16'd0, want})
			report_mismatch("max_error readback", 64'(prdata), 64'(want));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_write_max_error(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MAX_ERROR;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cor_max_error = value;
		cfg_writes++;
		apb_read_check(value);
	endtask

	function automatic void add_row(input int err, input logic [63:0] key,
			input logic [30:0] pos, input bit fin, input int tn, input logic [63:0] tkey,
			input logic [30:0] tpos);
		stim_row_t row;
		row.err = err;
		row.pt.point_key = key;
		row.pt.point_position = pos;
		row.pt.stream_end = fin;
		row.tn = tn;
		row.tk.knot_key = tkey;
		row.tk.knot_position = tpos;
		row.tk.run_last = 1'b1;
		stim_rows = {stim_rows, row};
	endfunction

	// Random sorted streams: mostly well-formed runs along a drifting line
	// with noise near max_error, plus repeated keys, position jumps, key wrap,
	// lone points and a stream_end that may land on a dropped point.
	task automatic run_streams(input int target);
		int          effective, len, slope, amp, noise, pick, i;
		logic [63:0] key, inc, dec;
		longint      pos, step;
		bit          noisy;
		point_t      pt;
		knot_t       none;
		none = '0;
		effective = 0;
		while (effective < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				len = 1;
			else if (pick < 90)
				len = $urandom_range(2, 24);
			else
				len = $urandom_range(25, 60);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				key = 64'($urandom_range(0, 1 << 30));
			else if (pick < 90)
				key = {$urandom, $urandom};
			else
				key = KEY_TOP - 64'($urandom_range(0, 5000));
			pick = $urandom_range(0, 99);
			if (pick < 50)
				pos = longint'($urandom_range(0, 1000000));
			else if (pick < 80)
				pos = longint'($urandom_range(0, 32'h7FFF_FFFF));
			else
				pos = 64'sh7FFF_FFFF - longint'($urandom_range(0, 100000));
			slope = int'($urandom_range(0, 800)) - 400;
			amp = (cor_max_error > 16'd4000) ? 4000 : int'(cor_max_error);
			for (i = 0; i < len; i++) begin
				pick = $urandom_range(0, 99);
				noisy = 1'b0;
				pt.point_key = key;
				if (i > 0 && pick < 6) begin
					// key not above the end: dropped by the block
					dec = 64'($urandom_range(0, 3));
					pt.point_key = key - ((key < dec) ? key : dec);
					noisy = 1'b1;
				end else if (i > 0) begin
					pick = $urandom_range(0, 99);
					if (pick < 70)
						inc = 64'($urandom_range(1, 64));
					else if (pick < 90)
						inc = 64'($urandom_range(1, 1 << 20));
					else
						inc = ({$urandom, $urandom} >> $urandom_range(0, 40)) + 64'd1;
					step = (longint'((inc > 64'd16777216) ? 64'd16777216 : inc)
						* longint'(slope)) / 16;
					noise = int'($urandom_range(0, 2 * amp + 2)) - amp - 1;
					if ($urandom_range(0, 99) < 15)
						noise = noise * 3;
					if ($urandom_range(0, 99) < 10)
						pos = longint'($urandom_range(0, 32'h7FFF_FFFF));
					else
						pos = pos + step + longint'(noise);
					pt.point_key = key + inc;
					if (key + inc < key)
						noisy = 1'b1; // wrapped: lands below the end
					else
						key = key + inc;
					if ($urandom_range(0, 99) < 8)
						slope = int'($urandom_range(0, 800)) - 400;
				end
				if (pos < 0)
					pos = 0;
				if (pos > POS_TOP)
					pos = POS_TOP;
				pt.point_position = pos[30:0];
				pt.stream_end = (i == len - 1);
				feed_point(pt, 1'b0, 0, none);
				if (!noisy)
					effective++;
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : main_seq
		int        i, seg;
		stim_row_t row;
		logic [15:0] seg_err;
		cor_max_error = MAX_ERROR_RESET;
		corridor_clear();
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of max_error, before any write
		apb_read_check(16'd32);

		// first point, dropped keys, extremes, lone points, stream_end on a
		// dropped point, falling positions, collapsed corridor, widest corridor
		add_row(-1, 64'd5, 31'd100, 1'b0, 1, 64'd5, 31'd100);
		add_row(-1, 64'd5, 31'd7, 1'b0, 0, '0, '0);
		add_row(-1, 64'd3, 31'd9, 1'b0, 0, '0, '0);
		add_row(-1, 64'd10, 31'd110, 1'b0, -1, '0, '0);
		add_row(-1, 64'd20, 31'd120, 1'b0, -1, '0, '0);
		add_row(-1, 64'd21, 31'd0, 1'b0, -1, '0, '0);
		add_row(-1, 64'd30, POS_MAX, 1'b0, -1, '0, '0);
		add_row(-1, 64'd31, 31'd0, 1'b1, -1, '0, '0);
		add_row(-1, 64'd0, 31'd0, 1'b1, 1, 64'd0, 31'd0);
		add_row(-1, KEY_TOP, POS_MAX, 1'b1, 1, KEY_TOP, POS_MAX);
		add_row(-1, 64'd0, POS_MAX, 1'b0, 1, 64'd0, POS_MAX);
		add_row(-1, KEY_TOP, 31'd0, 1'b0, 0, '0, '0);
		add_row(-1, KEY_TOP, 31'd5, 1'b1, 1, KEY_TOP, 31'd0);
		add_row(-1, 64'd100, 31'd50, 1'b0, 1, 64'd100, 31'd50);
		add_row(-1, 64'd101, 31'd50, 1'b1, 1, 64'd101, 31'd50);
		add_row(-1, 64'd200, 31'd1000, 1'b0, 1, 64'd200, 31'd1000);
		add_row(-1, 64'd210, 31'd900, 1'b0, -1, '0, '0);
		add_row(-1, 64'd220, 31'd800, 1'b0, -1, '0, '0);
		add_row(-1, 64'd230, 31'd1500, 1'b1, -1, '0, '0);
		add_row(0, 64'd1000, 31'd0, 1'b0, 1, 64'd1000, 31'd0);
		add_row(-1, 64'd1010, 31'd10, 1'b0, -1, '0, '0);
		add_row(-1, 64'd1020, 31'd20, 1'b0, -1, '0, '0);
		add_row(-1, 64'd1030, 31'd30, 1'b1, -1, '0, '0);
		add_row(65535, 64'd0, 31'd0, 1'b0, 1, 64'd0, 31'd0);
		add_row(-1, 64'd1, POS_MAX, 1'b0, -1, '0, '0);
		add_row(-1, 64'd2, 31'd0, 1'b1, -1, '0, '0);

		for (i = 0; i < stim_rows.size(); i++) begin
			row = stim_rows[i];
			if (row.err >= 0) begin
				drain_knots();
				apb_write_max_error(row.err[15:0]);
			end
			feed_point(row.pt, row.tn >= 0, row.tn, row.tk);
		end

		// random segments: three idle mixes, two max_error settings each
		for (seg = 0; seg < 6; seg++) begin
			tx_idle_pct = (seg < 2) ? 13 : (seg < 4) ? 50 : 0;
			rx_idle_pct = (seg < 2) ? 50 : (seg < 4) ? 13 : 0;
			case (seg)
				0: seg_err = 16'd0;
				1: seg_err = 16'hFFFF;
				2: seg_err = 16'd32;
				3: seg_err = 16'($urandom_range(1, 16));
				4: seg_err = 16'($urandom_range(0, 65535));
				default: seg_err = 16'd1;
			endcase
			drain_knots();
			apb_write_max_error(seg_err);
			// receiver holds off while points keep coming, so the block backs up
			if (seg == 1)
				hold_req = 1'b1;
			run_streams(SEGMENT_POINTS);
		end

		drain_knots();
		$display("covered %0d point transactions (%0d directed) and %0d knot transactions",
			points_sent, stim_rows.size(), knots_seen);
		$display("%0d max_error writes incl. 0 and 65535; idle mixes 13/50, 50/13 and none",
			cfg_writes);
		if (mismatches == 0 && pending_knots.size() == 0)
			$display("greedy_spline_corridor_builder_tb OK");
		else
			$display("greedy_spline_corridor_builder_tb NOT OK");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("timeout with %0d knots pending", pending_knots.size());
		$display("greedy_spline_corridor_builder_tb NOT OK");
		$finish;
	end

endmodule

/* files.f */
design/gscb_pkg.sv
design/gscb_cmp_unit.sv
design/greedy_spline_corridor_builder.sv
test/greedy_spline_corridor_builder_tb.sv
